### src/csfi_pkg.sv
// Shared types and constants for the circle segment free interval block.
package csfi_pkg;

    localparam int PARAM_FRAC_BITS = 30;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTER_MARGIN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_TOL   = CFG_INDEX_W'(1);

    localparam logic [30:0] OUTER_MARGIN_RESET = 31'd16;
    localparam logic [30:0] SEARCH_TOL_RESET   = 31'd8;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [30:0] radius;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic               is_empty;
        logic        [30:0] free_begin;
        logic        [30:0] free_end;
        logic signed [31:0] outer_begin;
        logic signed [31:0] outer_end;
    } out_item_t;

endpackage

### src/circle_segment_free_interval.sv
// Circle / segment inside-interval finder with a shared multiplier under a sequencer.
//
// Usage:
//   s_valid/s_ready/s_data carry one circle plus one segment (Q16.16 coordinates).
//   m_valid/m_ready/m_data return one result per item: empty flag, the inside
//   interval [free_begin, free_end] in Q1.30 and the outer bounds widened by the
//   margin. cfg_valid/cfg_ready/cfg_index/cfg_data write outer_margin (index 0)
//   and search_tolerance (index 1); cfg_ready is always high. Write them only
//   while the block is idle.
//   Steps from the input transfer to m_valid: quadratic terms, two 128-step
//   bit-serial divisions, 32 square root steps, then inside tests on the shared
//   33x33 multiplier (three fixed ones, up to two root checks per side and one
//   per bisection step, about 58 steps in all at tolerance 1). A degenerate
//   segment skips both divisions. s_ready is high only while the sequencer is
//   idle, so the block takes no new item until it has finished the last one.
//   Reset (synchronous, aresetn low) idles the sequencer, drops any pending
//   result and loads margin 16 and tolerance 8.
//   A stalled receiver holds the result in the output register; the block still
//   takes the next item and finishes it, then waits until the register frees.
module circle_segment_free_interval (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  csfi_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output csfi_pkg::out_item_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csfi_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);

    localparam int PFB   = csfi_pkg::PARAM_FRAC_BITS;
    localparam int TW    = 36;                 // width of parameter values in flight
    localparam int NUM_W = 128;                // divider dividend width
    localparam int CNT_W = $clog2(NUM_W);

    localparam logic signed [TW-1:0] ONE_T   = TW'(1) << PFB;
    localparam logic signed [TW-1:0] T_LIM   = TW'(1) << 31;
    localparam logic signed [TW-1:0] SAT_HI  = TW'(32'h7FFF_FFFF);
    localparam logic signed [TW-1:0] SAT_LO  = -SAT_HI - TW'(1);
    localparam logic [63:0]          MID_LIM = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0]          CQ_LIM  = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [5:0] {
        ST_IDLE, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6, ST_A7,
        ST_DIVM, ST_MIDSET, ST_DIVC, ST_CQSET, ST_DISC0, ST_DISC1, ST_SQRT,
        ST_TZ, ST_TO, ST_TM, ST_DEC,
        ST_B0, ST_B1, ST_B2, ST_BB, ST_BB2,
        ST_E0, ST_E1, ST_E2, ST_EB, ST_EB2,
        ST_FIN, ST_DONE,
        ST_IN0, ST_IN1, ST_IN2, ST_IN3, ST_IN4
    } state_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] x);
        return x[32] ? 33'(-x) : 33'(x);
    endfunction

    function automatic logic [TW-1:0] magt(input logic signed [TW-1:0] x);
        return x[TW-1] ? TW'(-x) : TW'(x);
    endfunction

    // floor(t*v / ONE) from the magnitude product and the sign of the product
    function automatic logic signed [TW-1:0] scale_t(input logic [65:0] m, input logic neg);
        logic [65:0] up;
        up = m + 66'((67'd1 << PFB) - 67'd1);
        return neg ? -TW'(up >> PFB) : TW'(m >> PFB);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [TW-1:0] x);
        if (x > SAT_HI) return 32'(SAT_HI);
        if (x < SAT_LO) return 32'(SAT_LO);
        return 32'(x);
    endfunction

    function automatic logic [30:0] clamp_free(input logic signed [TW-1:0] x);
        if (x < 0) return 31'd0;
        if (x > ONE_T) return 31'(ONE_T);
        return 31'(x);
    endfunction

    function automatic logic signed [TW-1:0] smin(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [TW-1:0] smax(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    state_t state_reg, ret_reg;

    // configuration
    logic [30:0] margin_reg, tol_cfg_reg;

    // item geometry and quadratic terms
    logic signed [32:0] dx_reg, dy_reg, vx_reg, vy_reg;
    logic        [30:0] r_reg;
    logic        [65:0] a_reg;
    logic signed [67:0] b_reg, c_reg;
    logic        [61:0] r2_reg;

    // shared multiplier
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod_reg;

    // bit-serial divider
    logic [NUM_W-1:0] num_reg;
    logic [66:0]      rem_reg;
    logic [63:0]      quo_reg;
    logic             qovf_reg;
    logic [CNT_W-1:0] cnt_reg;

    // square root
    logic [63:0] sq_x_reg, sq_res_reg, sq_bit_reg;

    // roots, tests and interval ends
    logic signed [TW-1:0] mid_reg, t_reg, px_reg, py_reg;
    logic signed [63:0]   cq_reg;
    logic        [64:0]   sq_acc_reg;
    logic                 in_res_reg, z_reg, o_reg;
    logic signed [TW-1:0] inner_reg, outer_reg, lo_reg, hi_reg;
    logic signed [TW-1:0] begin_reg, ob_reg, end_reg, oe_reg;

    csfi_pkg::out_item_t res_reg, m_data_reg;
    logic                m_valid_reg;

    // derived values
    logic [32:0]          dxm, dym, vxm, vym, midm;
    logic signed [TW-1:0] ts;
    logic [TW-1:0]        ts_mag, ax, ay;
    logic                 t_neg;
    logic [66:0]          rem_sh, rem_sub;
    logic                 div_ge;
    logic [67:0]          b_mag, c_mag;
    logic [63:0]          q_mid, q_cq;
    logic signed [64:0]   disc;
    logic [64:0]          sq_sum;
    logic                 in_ok;
    logic [30:0]          tol_eff;
    logic signed [TW-1:0] tol_s, h_s, eps_s, sd_s;
    logic signed [TW-1:0] mid2, l1, l2, inner_b, outer_b, inner_e, outer_e, bis_m;
    logic                 mi2, is_empty_c, bis_go;
    logic [TW-1:0]        midm_t;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign dxm    = mag33(dx_reg);
    assign dym    = mag33(dy_reg);
    assign vxm    = mag33(vx_reg);
    assign vym    = mag33(vy_reg);
    assign midm_t = magt(mid_reg);
    assign midm   = midm_t[32:0];

    // saturate the test parameter to +-2^31
    assign ts     = (t_reg > T_LIM) ? T_LIM : ((t_reg < -T_LIM) ? -T_LIM : t_reg);
    assign ts_mag = magt(ts);
    assign t_neg  = ts[TW-1];
    assign ax     = magt(px_reg);
    assign ay     = magt(py_reg);
    assign in_ok  = (ax <= TW'(r_reg)) && (ay <= TW'(r_reg)) &&
                    (sq_acc_reg + 65'(prod_reg[63:0]) <= 65'(r2_reg));

    assign rem_sh  = {rem_reg[65:0], num_reg[NUM_W-1]};
    assign div_ge  = rem_sh >= {1'b0, a_reg};
    assign rem_sub = rem_sh - {1'b0, a_reg};
    assign b_mag   = b_reg[67] ? 68'(-b_reg) : 68'(b_reg);
    assign c_mag   = c_reg[67] ? 68'(-c_reg) : 68'(c_reg);
    assign q_mid   = (qovf_reg || quo_reg > MID_LIM) ? MID_LIM : quo_reg;
    assign q_cq    = (qovf_reg || quo_reg > CQ_LIM) ? CQ_LIM : quo_reg;

    assign disc   = $signed({1'b0, prod_reg[63:0]}) - 65'(cq_reg);
    assign sq_sum = 65'(sq_res_reg) + 65'(sq_bit_reg);

    assign tol_eff = (tol_cfg_reg == 31'd0) ? 31'd1 : tol_cfg_reg;
    assign tol_s   = TW'(tol_eff);
    assign h_s     = TW'(tol_eff >> 1);
    assign eps_s   = TW'(margin_reg);
    assign sd_s    = TW'(sq_res_reg);

    // move the center point to a segment end that is inside when it fails
    always_comb begin
        mid2 = mid_reg;
        mi2  = in_res_reg;
        if (!in_res_reg && z_reg) begin
            mid2 = '0;
            mi2  = 1'b1;
        end else if (!in_res_reg && o_reg) begin
            mid2 = ONE_T;
            mi2  = 1'b1;
        end
        is_empty_c = !mi2 || (mid2 <= 0 && !z_reg) || (mid2 >= ONE_T && !o_reg);
    end

    assign l1      = mid_reg - sd_s;
    assign inner_b = smin(l1 + h_s, smin(ONE_T, mid_reg));
    assign outer_b = l1 - h_s;
    assign l2      = mid_reg + sd_s;
    assign inner_e = smax(l2 - h_s, smax(TW'(0), mid_reg));
    assign outer_e = l2 + h_s;
    assign bis_go  = (hi_reg - lo_reg) > tol_s;
    assign bis_m   = (lo_reg + hi_reg) >>> 1;

    // operand select for the shared multiplier; the product is registered in the cycle after
    always_comb begin
        case (state_reg)
            ST_A0:    begin mul_a = vxm;            mul_b = vxm;            end
            ST_A1:    begin mul_a = vym;            mul_b = vym;            end
            ST_A2:    begin mul_a = dxm;            mul_b = vxm;            end
            ST_A3:    begin mul_a = dym;            mul_b = vym;            end
            ST_A4:    begin mul_a = dxm;            mul_b = dxm;            end
            ST_A5:    begin mul_a = dym;            mul_b = dym;            end
            ST_A6:    begin mul_a = 33'(r_reg);     mul_b = 33'(r_reg);     end
            ST_DISC0: begin mul_a = midm;           mul_b = midm;           end
            ST_IN0:   begin mul_a = ts_mag[32:0];   mul_b = vxm;            end
            ST_IN1:   begin mul_a = ts_mag[32:0];   mul_b = vym;            end
            ST_IN2:   begin mul_a = ax[32:0];       mul_b = ax[32:0];       end
            ST_IN3:   begin mul_a = ay[32:0];       mul_b = ay[32:0];       end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            m_valid_reg <= 1'b0;
            margin_reg  <= csfi_pkg::OUTER_MARGIN_RESET;
            tol_cfg_reg <= csfi_pkg::SEARCH_TOL_RESET;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    csfi_pkg::CFG_OUTER_MARGIN: margin_reg  <= cfg_data[30:0];
                    csfi_pkg::CFG_SEARCH_TOL:   tol_cfg_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end

            // drop the result once taken; ST_DONE reloads the register itself
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        dx_reg    <= 33'(s_data.start_x) - 33'(s_data.center_x);
                        dy_reg    <= 33'(s_data.start_y) - 33'(s_data.center_y);
                        vx_reg    <= 33'(s_data.end_x) - 33'(s_data.start_x);
                        vy_reg    <= 33'(s_data.end_y) - 33'(s_data.start_y);
                        r_reg     <= s_data.radius;
                        state_reg <= ST_A0;
                    end
                end
                ST_A0: state_reg <= ST_A1;
                ST_A1: begin
                    a_reg     <= prod_reg;
                    state_reg <= ST_A2;
                end
                ST_A2: begin
                    a_reg     <= a_reg + prod_reg;
                    state_reg <= ST_A3;
                end
                ST_A3: begin
                    b_reg     <= (dx_reg[32] != vx_reg[32]) ? -68'(prod_reg) : 68'(prod_reg);
                    state_reg <= ST_A4;
                end
                ST_A4: begin
                    b_reg     <= (dy_reg[32] != vy_reg[32]) ? b_reg - 68'(prod_reg)
                                                             : b_reg + 68'(prod_reg);
                    state_reg <= ST_A5;
                end
                ST_A5: begin
                    c_reg     <= 68'(prod_reg);
                    state_reg <= ST_A6;
                end
                ST_A6: begin
                    c_reg     <= c_reg + 68'(prod_reg);
                    state_reg <= ST_A7;
                end
                ST_A7: begin
                    r2_reg   <= prod_reg[61:0];
                    c_reg    <= c_reg - 68'(prod_reg);
                    num_reg  <= NUM_W'(b_mag) << PFB;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    qovf_reg <= 1'b0;
                    cnt_reg  <= '0;
                    // degenerate segment: center and discriminant are zero
                    if (a_reg == '0) begin
                        mid_reg   <= '0;
                        cq_reg    <= '0;
                        state_reg <= ST_DISC0;
                    end else begin
                        state_reg <= ST_DIVM;
                    end
                end
                ST_DIVM, ST_DIVC: begin
                    num_reg  <= num_reg << 1;
                    rem_reg  <= div_ge ? rem_sub : rem_sh;
                    quo_reg  <= {quo_reg[62:0], div_ge};
                    qovf_reg <= qovf_reg | quo_reg[63];
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                        state_reg <= (state_reg == ST_DIVM) ? ST_MIDSET : ST_CQSET;
                    end
                end
                ST_MIDSET: begin
                    mid_reg   <= b_reg[67] ? TW'(q_mid) : -TW'(q_mid);
                    num_reg   <= NUM_W'(c_mag) << (2 * PFB);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    qovf_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIVC;
                end
                ST_CQSET: begin
                    cq_reg    <= c_reg[67] ? -$signed(q_cq) : $signed(q_cq);
                    state_reg <= ST_DISC0;
                end
                ST_DISC0: state_reg <= ST_DISC1;
                ST_DISC1: begin
                    sq_x_reg   <= disc[64] ? 64'd0 : disc[63:0];
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (65'(sq_x_reg) >= sq_sum) begin
                        sq_x_reg   <= sq_x_reg - sq_sum[63:0];
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg == 64'd1) begin
                        state_reg <= ST_TZ;
                    end
                end
                ST_TZ: begin
                    t_reg     <= '0;
                    ret_reg   <= ST_TO;
                    state_reg <= ST_IN0;
                end
                ST_TO: begin
                    z_reg     <= in_res_reg;
                    t_reg     <= ONE_T;
                    ret_reg   <= ST_TM;
                    state_reg <= ST_IN0;
                end
                ST_TM: begin
                    o_reg     <= in_res_reg;
                    t_reg     <= mid_reg;
                    ret_reg   <= ST_DEC;
                    state_reg <= ST_IN0;
                end
                ST_DEC: begin
                    mid_reg <= mid2;
                    if (z_reg && o_reg) begin
                        res_reg.is_empty    <= 1'b0;
                        res_reg.free_begin  <= '0;
                        res_reg.free_end    <= 31'(ONE_T);
                        res_reg.outer_begin <= sat32(-eps_s);
                        res_reg.outer_end   <= sat32(ONE_T + eps_s);
                        state_reg           <= ST_DONE;
                    end else if (is_empty_c) begin
                        res_reg   <= '{1'b1, 31'd0, 31'd0, 32'sd0, 32'sd0};
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_B0;
                    end
                end

                // lower end of the interval
                ST_B0: begin
                    inner_reg <= inner_b;
                    outer_reg <= outer_b;
                    lo_reg    <= '0;
                    hi_reg    <= smin(mid_reg, ONE_T);
                    if (z_reg) begin
                        begin_reg <= '0;
                        ob_reg    <= -eps_s;
                        state_reg <= ST_E0;
                    end else if (inner_b >= outer_b) begin
                        t_reg     <= inner_b;
                        ret_reg   <= ST_B1;
                        state_reg <= ST_IN0;
                    end else begin
                        state_reg <= ST_BB;
                    end
                end
                ST_B1: begin
                    if (in_res_reg) begin
                        t_reg     <= outer_reg;
                        ret_reg   <= ST_B2;
                        state_reg <= ST_IN0;
                    end else begin
                        state_reg <= ST_BB;
                    end
                end
                ST_B2: begin
                    if (!in_res_reg) begin
                        begin_reg <= inner_reg;
                        ob_reg    <= outer_reg;
                        state_reg <= ST_E0;
                    end else begin
                        state_reg <= ST_BB;
                    end
                end
                ST_BB: begin
                    if (bis_go) begin
                        t_reg     <= bis_m;
                        ret_reg   <= ST_BB2;
                        state_reg <= ST_IN0;
                    end else begin
                        begin_reg <= hi_reg;
                        ob_reg    <= lo_reg;
                        state_reg <= ST_E0;
                    end
                end
                ST_BB2: begin
                    if (in_res_reg) hi_reg <= t_reg;
                    else lo_reg <= t_reg;
                    state_reg <= ST_BB;
                end

                // upper end of the interval
                ST_E0: begin
                    inner_reg <= inner_e;
                    outer_reg <= outer_e;
                    lo_reg    <= smax(mid_reg, TW'(0));
                    hi_reg    <= ONE_T;
                    if (o_reg) begin
                        end_reg   <= ONE_T;
                        oe_reg    <= ONE_T + eps_s;
                        state_reg <= ST_FIN;
                    end else if (inner_e <= outer_e) begin
                        t_reg     <= inner_e;
                        ret_reg   <= ST_E1;
                        state_reg <= ST_IN0;
                    end else begin
                        state_reg <= ST_EB;
                    end
                end
                ST_E1: begin
                    if (in_res_reg) begin
                        t_reg     <= outer_reg;
                        ret_reg   <= ST_E2;
                        state_reg <= ST_IN0;
                    end else begin
                        state_reg <= ST_EB;
                    end
                end
                ST_E2: begin
                    if (!in_res_reg) begin
                        end_reg   <= inner_reg;
                        oe_reg    <= outer_reg;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_EB;
                    end
                end
                ST_EB: begin
                    if (bis_go) begin
                        t_reg     <= bis_m;
                        ret_reg   <= ST_EB2;
                        state_reg <= ST_IN0;
                    end else begin
                        end_reg   <= lo_reg;
                        oe_reg    <= hi_reg;
                        state_reg <= ST_FIN;
                    end
                end
                ST_EB2: begin
                    if (in_res_reg) lo_reg <= t_reg;
                    else hi_reg <= t_reg;
                    state_reg <= ST_EB;
                end

                ST_FIN: begin
                    res_reg.is_empty    <= 1'b0;
                    res_reg.free_begin  <= clamp_free(begin_reg);
                    res_reg.free_end    <= clamp_free(end_reg);
                    res_reg.outer_begin <= sat32(ob_reg);
                    res_reg.outer_end   <= sat32(oe_reg);
                    state_reg           <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                // inside test of t_reg, returns to ret_reg with in_res_reg
                ST_IN0: state_reg <= ST_IN1;
                ST_IN1: begin
                    px_reg    <= dx_reg + scale_t(prod_reg, t_neg != vx_reg[32]);
                    state_reg <= ST_IN2;
                end
                ST_IN2: begin
                    py_reg    <= dy_reg + scale_t(prod_reg, t_neg != vy_reg[32]);
                    state_reg <= ST_IN3;
                end
                ST_IN3: begin
                    sq_acc_reg <= 65'(prod_reg[63:0]);
                    state_reg  <= ST_IN4;
                end
                ST_IN4: begin
                    in_res_reg <= in_ok;
                    state_reg  <= ret_reg;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
